### hdl/bounded_greedy_change_dispenser_macros.svh
// Assertion macros for the checker file of the change dispenser.
// Each macro takes a label, the clock and the reset, then the property terms.
`ifndef BOUNDED_GREEDY_CHANGE_DISPENSER_MACROS_SVH
`define BOUNDED_GREEDY_CHANGE_DISPENSER_MACROS_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define BGCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("change dispenser assertion failed");

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define BGCD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("change dispenser assertion failed");

// The consequent must hold in the cycle after reset is seen high.
`define BGCD_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("change dispenser reset assertion failed");

`endif

### hdl/bgcd_pkg.sv
`timescale 1ns / 1ps

package bgcd_pkg;

  // Coin set and field widths.
  localparam int COIN_KINDS         = 7;
  localparam int COIN_IDX_BITS      = 3;
  localparam int COUNT_BITS         = 8;
  localparam int AMOUNT_BITS        = 8;
  localparam int REST_BITS          = 15;
  localparam int GIVE_BITS          = 16;
  localparam int STOCK_BITS_DEFAULT = 16;
  localparam int COIN_VALUE_BITS    = 5;

  // Queue depths between the front, the back and the result port.
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Constant division by a coin value: multiply by a rounded-up reciprocal
  // and keep the bits above RECIP_SHIFT. Exact for every amount below 2^15.
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_BITS  = RECIP_SHIFT + 1;

  localparam logic [COIN_VALUE_BITS-1:0] COIN_VALUE [COIN_KINDS] = '{
    5'd17, 5'd11, 5'd7, 5'd5, 5'd3, 5'd2, 5'd1
  };

  localparam logic [RECIP_BITS-1:0] COIN_RECIP [COIN_KINDS] = '{
    RECIP_BITS'((2**RECIP_SHIFT + 16) / 17),
    RECIP_BITS'((2**RECIP_SHIFT + 10) / 11),
    RECIP_BITS'((2**RECIP_SHIFT + 6) / 7),
    RECIP_BITS'((2**RECIP_SHIFT + 4) / 5),
    RECIP_BITS'((2**RECIP_SHIFT + 2) / 3),
    RECIP_BITS'((2**RECIP_SHIFT + 1) / 2),
    RECIP_BITS'(2**RECIP_SHIFT)
  };

  localparam logic [COIN_IDX_BITS-1:0] LAST_COIN = COIN_IDX_BITS'(COIN_KINDS - 1);

  // Operation codes on the input.
  localparam logic OP_REFILL = 1'b0;
  localparam logic OP_CHANGE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_UNDERPAY = 2'd2
  } status_t;

  // Classes of work that the front hands to the back.
  typedef enum logic [1:0] {
    CMD_REFILL = 2'd0,
    CMD_CHANGE = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    status_t                  status;
    logic [COIN_IDX_BITS-1:0] coin_index;
    logic [COUNT_BITS-1:0]    coin_count;
    logic [REST_BITS-1:0]     rest;
  } cmd_t;

  typedef struct packed {
    status_t                                status;
    logic [COIN_KINDS-1:0][GIVE_BITS-1:0]   give;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_SUB  = 2'd2,
    BK_DONE = 2'd3
  } back_state_t;

endpackage

### hdl/bgcd_fifo.sv
`timescale 1ns / 1ps

module bgcd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = entry[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset; the count marks what is valid.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= wdata;
    end
  end

endmodule

### hdl/bgcd_front.sv
`timescale 1ns / 1ps

module bgcd_front import bgcd_pkg::*; (
  input  logic                     operation,
  input  logic [COIN_IDX_BITS-1:0] coin_index,
  input  logic [COUNT_BITS-1:0]    coin_count,
  input  logic [AMOUNT_BITS-1:0]   paid,
  input  logic [AMOUNT_BITS-1:0]   price,
  output cmd_t                     cmd
);

  logic [AMOUNT_BITS-1:0] diff;
  logic [REST_BITS-1:0]   diff_ext;
  logic [REST_BITS-1:0]   rest100;

  // The change amount is the difference times 100, built from three shifts.
  assign diff     = paid - price;
  assign diff_ext = REST_BITS'(diff);
  assign rest100  = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);

  // Sort each transaction into a refill, a change split or a fixed report.
  always_comb begin
    cmd.kind       = CMD_REPORT;
    cmd.status     = STATUS_OK;
    cmd.coin_index = coin_index;
    cmd.coin_count = coin_count;
    cmd.rest       = rest100;
    if (operation == OP_REFILL) begin
      if (coin_index < COIN_IDX_BITS'(COIN_KINDS)) begin
        cmd.kind = CMD_REFILL;
      end
    end else if (paid < price) begin
      cmd.status = STATUS_UNDERPAY;
    end else if (diff != '0) begin
      cmd.kind = CMD_CHANGE;
    end
  end

endmodule

### hdl/bgcd_back.sv
`timescale 1ns / 1ps

module bgcd_back import bgcd_pkg::*; #(
  parameter int STOCK_BITS = STOCK_BITS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  logic    cmd_empty,
  output logic    cmd_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  localparam int PROD_W = REST_BITS + RECIP_BITS;
  localparam int CMP_W  = (STOCK_BITS > REST_BITS) ? STOCK_BITS : REST_BITS;

  back_state_t              state;
  back_state_t              state_next;
  logic [COIN_IDX_BITS-1:0] step;
  logic [REST_BITS-1:0]     rest;
  logic [REST_BITS-1:0]     quot;
  logic [REST_BITS-1:0]     takes [COIN_KINDS];
  logic [STOCK_BITS-1:0]    stock [COIN_KINDS];

  logic                     refill_en;
  logic                     load_en;
  logic                     quot_en;
  logic                     sub_en;
  logic                     commit_en;

  logic [PROD_W-1:0]        prod;
  logic [REST_BITS-1:0]     quot_calc;
  logic [STOCK_BITS-1:0]    stock_sel;
  logic [REST_BITS-1:0]     take;
  logic [REST_BITS-1:0]     cost;

  // Quotient of the remaining amount by the current coin value.
  assign prod      = PROD_W'(rest) * PROD_W'(COIN_RECIP[step]);
  assign quot_calc = prod[RECIP_SHIFT +: REST_BITS];

  // Take as many coins as wanted, but no more than the stock holds.
  assign stock_sel = stock[step];
  assign take      = (CMP_W'(quot) < CMP_W'(stock_sel)) ? quot : REST_BITS'(stock_sel);
  assign cost      = REST_BITS'(take) * REST_BITS'(COIN_VALUE[step]);

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, queue handshakes and the result word.
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    refill_en  = 1'b0;
    load_en    = 1'b0;
    quot_en    = 1'b0;
    sub_en     = 1'b0;
    commit_en  = 1'b0;
    res.status = STATUS_OK;
    res.give   = '0;
    unique case (state)
      BK_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_REFILL: begin
              refill_en = 1'b1;
              res_push  = 1'b1;
            end
            CMD_CHANGE: begin
              load_en    = 1'b1;
              state_next = BK_DIV;
            end
            CMD_REPORT: begin
              res_push   = 1'b1;
              res.status = cmd.status;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      BK_DIV: begin
        quot_en    = 1'b1;
        state_next = BK_SUB;
      end
      BK_SUB: begin
        sub_en     = 1'b1;
        state_next = (step == LAST_COIN) ? BK_DONE : BK_DIV;
      end
      BK_DONE: begin
        res_push   = 1'b1;
        state_next = BK_IDLE;
        if (rest == '0) begin
          commit_en = 1'b1;
          for (int i = 0; i < COIN_KINDS; i++) begin
            res.give[i] = GIVE_BITS'(takes[i]);
          end
        end else begin
          res.status = STATUS_SHORT;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Coin inventory: saturating refill, and all counts taken at once on success.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COIN_KINDS; i++) begin
        stock[i] <= '0;
      end
    end else begin
      for (int i = 0; i < COIN_KINDS; i++) begin
        if (refill_en && (cmd.coin_index == COIN_IDX_BITS'(i))) begin
          if ({1'b0, stock[i]} + (STOCK_BITS + 1)'(cmd.coin_count) >
              (STOCK_BITS + 1)'({STOCK_BITS{1'b1}})) begin
            stock[i] <= '1;
          end else begin
            stock[i] <= stock[i] + STOCK_BITS'(cmd.coin_count);
          end
        end else if (commit_en) begin
          stock[i] <= stock[i] - STOCK_BITS'(takes[i]);
        end
      end
    end
  end

  // Greedy split datapath, one denomination per divide and subtract pair.
  always_ff @(posedge clk) begin
    if (load_en) begin
      rest <= cmd.rest;
      step <= '0;
    end
    if (quot_en) begin
      quot <= quot_calc;
    end
    if (sub_en) begin
      takes[step] <= take;
      rest        <= rest - cost;
      step        <= step + 1'b1;
    end
  end

endmodule

### hdl/bounded_greedy_change_dispenser.sv
`timescale 1ns / 1ps

// Change dispenser with a bounded inventory of seven coin kinds (17, 11, 7,
// 5, 3, 2, 1). Both sides look like a queue: push/full in, empty/pop out,
// one result per transaction in order. A front stage classifies each
// transaction into a two-entry command queue, and a back sequencer owns the
// inventory and writes into a two-entry result queue, so input keeps flowing
// while a result waits to be popped. In the back, a refill, an underpaid
// request or a request with no change is answered from the idle state; a
// change split runs a load step, then a divide step and a take-and-subtract
// step for each of the seven coin kinds through one shared reciprocal
// multiplier, then a commit step. At the earliest, a result passes the
// command queue and the result queue before it shows on the outputs, and
// it can be popped as soon as it shows. Stock counts are STOCK_BITS wide
// and saturate on refill; a failed split leaves the stock unchanged.
module bounded_greedy_change_dispenser import bgcd_pkg::*; #(
  parameter int STOCK_BITS = STOCK_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     operation,
  input  logic [COIN_IDX_BITS-1:0] coin_index,
  input  logic [COUNT_BITS-1:0]    coin_count,
  input  logic [AMOUNT_BITS-1:0]   paid,
  input  logic [AMOUNT_BITS-1:0]   price,
  output logic                     empty,
  input  logic                     pop,
  output logic [1:0]               status,
  output logic [GIVE_BITS-1:0]     give_seventeen,
  output logic [GIVE_BITS-1:0]     give_eleven,
  output logic [GIVE_BITS-1:0]     give_seven,
  output logic [GIVE_BITS-1:0]     give_five,
  output logic [GIVE_BITS-1:0]     give_three,
  output logic [GIVE_BITS-1:0]     give_two,
  output logic [GIVE_BITS-1:0]     give_one
);

  cmd_t    cmd_in;
  cmd_t    cmd_out;
  logic    cmd_empty;
  logic    cmd_pop;
  result_t res_in;
  result_t res_out;
  logic    res_full;
  logic    res_push;

  // Front: classify the incoming transaction.
  bgcd_front u_front (
    .operation  (operation),
    .coin_index (coin_index),
    .coin_count (coin_count),
    .paid       (paid),
    .price      (price),
    .cmd        (cmd_in)
  );

  bgcd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Back: inventory and greedy split.
  bgcd_back #(
    .STOCK_BITS (STOCK_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  bgcd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  // Result fields onto the ports.
  assign status         = res_out.status;
  assign give_seventeen = res_out.give[0];
  assign give_eleven    = res_out.give[1];
  assign give_seven     = res_out.give[2];
  assign give_five      = res_out.give[3];
  assign give_three     = res_out.give[4];
  assign give_two       = res_out.give[5];
  assign give_one       = res_out.give[6];

endmodule

### hdl/bgcd_checker.sv
`timescale 1ns / 1ps
`include "bounded_greedy_change_dispenser_macros.svh"

module bgcd_checker import bgcd_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     full,
  input logic                     empty,
  input logic                     pop,
  input logic [1:0]               status,
  input logic [GIVE_BITS-1:0]     give_seventeen,
  input logic [GIVE_BITS-1:0]     give_eleven,
  input logic [GIVE_BITS-1:0]     give_seven,
  input logic [GIVE_BITS-1:0]     give_five,
  input logic [GIVE_BITS-1:0]     give_three,
  input logic [GIVE_BITS-1:0]     give_two,
  input logic [GIVE_BITS-1:0]     give_one
);

  logic                                no_coins;
  logic [1+COIN_KINDS*GIVE_BITS:0]     result_word;

  assign no_coins = (give_seventeen == '0) && (give_eleven == '0) &&
                    (give_seven == '0) && (give_five == '0) &&
                    (give_three == '0) && (give_two == '0) && (give_one == '0);

  // Every field of the waiting result, for the hold check.
  assign result_word = {status, give_seventeen, give_eleven, give_seven, give_five,
                        give_three, give_two, give_one};

  // Reset drains both queues.
  `BGCD_ASSERT_AFTER_RESET(a_reset_empty, clk, rst, empty)
  `BGCD_ASSERT_AFTER_RESET(a_reset_not_full, clk, rst, !full)

  // A failed request never reports coins.
  `BGCD_ASSERT_NOW(a_error_no_coins, clk, rst, !empty && (status != STATUS_OK), no_coins)

  // A waiting result holds until it is popped.
  `BGCD_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(result_word))

endmodule

bind bounded_greedy_change_dispenser bgcd_checker u_checker (.*);

### sim/tb_bounded_greedy_change_dispenser.sv
`timescale 1ns / 1ps

module tb_bounded_greedy_change_dispenser import bgcd_pkg::*; ();

  localparam int STOCK_BITS  = STOCK_BITS_DEFAULT;
  localparam int STOCK_MAX   = (1 << STOCK_BITS) - 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 40;

  localparam int DENOM [COIN_KINDS] = '{17, 11, 7, 5, 3, 2, 1};

  // Receiver behavior, chosen anew whenever the low six phase bits are zero.
  typedef enum logic [1:0] {
    POP_ALWAYS = 2'd0,
    POP_HALF   = 2'd1,
    POP_SPARSE = 2'd2,
    POP_MOSTLY = 2'd3
  } pop_mode_t;

  // One row of the directed stimulus. Rows with has_status set carry the
  // expected status and expect every coin count to be zero.
  typedef struct packed {
    logic                     op;
    logic [COIN_IDX_BITS-1:0] idx;
    logic [COUNT_BITS-1:0]    cnt;
    logic [AMOUNT_BITS-1:0]   pd;
    logic [AMOUNT_BITS-1:0]   pr;
    logic                     has_status;
    status_t                  want_status;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 20;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Fresh after reset: nothing owed, underpaid, and an empty stock.
    '{OP_CHANGE, 3'd0, 8'd0,   8'd0,   8'd0,   1'b1, STATUS_OK},
    '{OP_CHANGE, 3'd0, 8'd0,   8'd0,   8'd255, 1'b1, STATUS_UNDERPAY},
    '{OP_CHANGE, 3'd0, 8'd0,   8'd255, 8'd0,   1'b1, STATUS_SHORT},
    '{OP_CHANGE, 3'd0, 8'd0,   8'd1,   8'd0,   1'b1, STATUS_SHORT},
    // Refill of the out-of-range index, then a full refill of every kind.
    '{OP_REFILL, 3'd7, 8'd255, 8'd0,   8'd0,   1'b1, STATUS_OK},
    '{OP_REFILL, 3'd0, 8'd255, 8'd0,   8'd0,   1'b1, STATUS_OK},
    '{OP_REFILL, 3'd1, 8'd255, 8'd0,   8'd0,   1'b1, STATUS_OK},
    '{OP_REFILL, 3'd2, 8'd255, 8'd0,   8'd0,   1'b1, STATUS_OK},
    '{OP_REFILL, 3'd3, 8'd255, 8'd0,   8'd0,   1'b1, STATUS_OK},
    '{OP_REFILL, 3'd4, 8'd255, 8'd0,   8'd0,   1'b1, STATUS_OK},
    '{OP_REFILL, 3'd5, 8'd255, 8'd0,   8'd0,   1'b1, STATUS_OK},
    '{OP_REFILL, 3'd6, 8'd255, 8'd0,   8'd0,   1'b1, STATUS_OK},
    '{OP_REFILL, 3'd0, 8'd0,   8'd255, 8'd255, 1'b1, STATUS_OK},
    // Splits and other rows against the stocked inventory, unused fields set as junk.
    '{OP_CHANGE, 3'd7, 8'd255, 8'd1,   8'd0,   1'b0, STATUS_OK},
    '{OP_CHANGE, 3'd0, 8'd0,   8'd255, 8'd0,   1'b0, STATUS_OK},
    '{OP_CHANGE, 3'd0, 8'd0,   8'd128, 8'd127, 1'b0, STATUS_OK},
    '{OP_CHANGE, 3'd0, 8'd0,   8'd200, 8'd190, 1'b0, STATUS_OK},
    '{OP_CHANGE, 3'd2, 8'd17,  8'd9,   8'd9,   1'b1, STATUS_OK},
    '{OP_REFILL, 3'd6, 8'd1,   8'd170, 8'd85,  1'b1, STATUS_OK},
    '{OP_CHANGE, 3'd5, 8'd0,   8'd3,   8'd4,   1'b1, STATUS_UNDERPAY}
  };

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     full;
  logic                     operation = OP_REFILL;
  logic [COIN_IDX_BITS-1:0] coin_index = '0;
  logic [COUNT_BITS-1:0]    coin_count = '0;
  logic [AMOUNT_BITS-1:0]   paid = '0;
  logic [AMOUNT_BITS-1:0]   price = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [1:0]               status;
  logic [GIVE_BITS-1:0]     give_seventeen;
  logic [GIVE_BITS-1:0]     give_eleven;
  logic [GIVE_BITS-1:0]     give_seven;
  logic [GIVE_BITS-1:0]     give_five;
  logic [GIVE_BITS-1:0]     give_three;
  logic [GIVE_BITS-1:0]     give_two;
  logic [GIVE_BITS-1:0]     give_one;

  int unsigned coin_stock_copy [COIN_KINDS] = '{default: 0};
  result_t     expected_payouts [$];
  result_t     oldest_payout;
  int          fail_count = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  int unsigned pop_phase = 0;
  pop_mode_t   pop_mode = POP_ALWAYS;

  bounded_greedy_change_dispenser #(
    .STOCK_BITS(STOCK_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .operation(operation),
    .coin_index(coin_index),
    .coin_count(coin_count),
    .paid(paid),
    .price(price),
    .empty(empty),
    .pop(pop),
    .status(status),
    .give_seventeen(give_seventeen),
    .give_eleven(give_eleven),
    .give_seven(give_seven),
    .give_five(give_five),
    .give_three(give_three),
    .give_two(give_two),
    .give_one(give_one)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Expected payout for one transaction; updates the inventory copy.
  function automatic result_t predict_payout(input logic op,
                                             input logic [COIN_IDX_BITS-1:0] idx,
                                             input logic [COUNT_BITS-1:0] cnt,
                                             input logic [AMOUNT_BITS-1:0] pd,
                                             input logic [AMOUNT_BITS-1:0] pr);
    result_t     payout;
    int unsigned owed;
    int unsigned want;
    int unsigned sum;
    int unsigned take [COIN_KINDS];
    payout = '0;
    if (op == OP_REFILL) begin
      if (idx <= LAST_COIN) begin
        sum = coin_stock_copy[idx] + cnt;
        coin_stock_copy[idx] = (sum > STOCK_MAX) ? STOCK_MAX : sum;
      end
      return payout;
    end
    if (pd < pr) begin
      payout.status = STATUS_UNDERPAY;
      return payout;
    end
    // Greedy split, largest coin first, bounded by what is in stock.
    owed = (int'(pd) - int'(pr)) * 100;
    for (int i = 0; i < COIN_KINDS; i++) begin
      want = owed / DENOM[i];
      take[i] = (want < coin_stock_copy[i]) ? want : coin_stock_copy[i];
      owed -= take[i] * DENOM[i];
    end
    if (owed != 0) begin
      payout.status = STATUS_SHORT;
      return payout;
    end
    for (int i = 0; i < COIN_KINDS; i++) begin
      coin_stock_copy[i] -= take[i];
      payout.give[i] = GIVE_BITS'(take[i]);
    end
    return payout;
  endfunction

  function automatic void check_field(input string name, input logic [GIVE_BITS-1:0] want,
                                      input logic [GIVE_BITS-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Send one transaction, with burst gaps, and record its expected payout.
  task automatic send_item(input logic op, input logic [COIN_IDX_BITS-1:0] idx,
                           input logic [COUNT_BITS-1:0] cnt,
                           input logic [AMOUNT_BITS-1:0] pd,
                           input logic [AMOUNT_BITS-1:0] pr,
                           input logic has_status, input status_t want_status);
    result_t payout;
    if (burst_left == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    operation = op;
    coin_index = idx;
    coin_count = cnt;
    paid = pd;
    price = pr;
    push = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    payout = predict_payout(op, idx, cnt, pd, pr);
    if (has_status) begin
      payout = '0;
      payout.status = want_status;
    end
    expected_payouts.push_back(payout);
    @(negedge clk);
    push = 1'b0;
  endtask

  // Hold the sender until every expected result has been popped.
  task automatic wait_for_results();
    push = 1'b0;
    while (expected_payouts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly refills and small well-formed change requests, plus some noise.
  task automatic send_random_mix(input int count);
    int                     pick;
    int                     diff;
    logic [AMOUNT_BITS-1:0] pr;
    logic [AMOUNT_BITS-1:0] pd;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_item(OP_REFILL, COIN_IDX_BITS'($urandom_range(0, COIN_KINDS - 1)),
                  COUNT_BITS'($urandom_range(0, 255)),
                  AMOUNT_BITS'($urandom_range(0, 255)),
                  AMOUNT_BITS'($urandom_range(0, 255)), 1'b0, STATUS_OK);
      end else if (pick < 50) begin
        send_item(OP_REFILL, 3'd7, COUNT_BITS'($urandom_range(0, 255)),
                  AMOUNT_BITS'($urandom_range(0, 255)),
                  AMOUNT_BITS'($urandom_range(0, 255)), 1'b0, STATUS_OK);
      end else if (pick < 85) begin
        diff = $urandom_range(0, 8);
        pr = AMOUNT_BITS'($urandom_range(0, 255 - diff));
        pd = AMOUNT_BITS'(int'(pr) + diff);
        send_item(OP_CHANGE, COIN_IDX_BITS'($urandom_range(0, 7)),
                  COUNT_BITS'($urandom_range(0, 255)), pd, pr, 1'b0, STATUS_OK);
      end else if (pick < 93) begin
        send_item(OP_CHANGE, COIN_IDX_BITS'($urandom_range(0, 7)),
                  COUNT_BITS'($urandom_range(0, 255)),
                  AMOUNT_BITS'($urandom_range(0, 255)),
                  AMOUNT_BITS'($urandom_range(0, 255)), 1'b0, STATUS_OK);
      end else begin
        pr = AMOUNT_BITS'($urandom_range(1, 255));
        pd = AMOUNT_BITS'($urandom_range(0, int'(pr) - 1));
        send_item(OP_CHANGE, COIN_IDX_BITS'($urandom_range(0, 7)),
                  COUNT_BITS'($urandom_range(0, 255)), pd, pr, 1'b0, STATUS_OK);
      end
    end
  endtask

  // Receiver: pop pattern whose character is picked anew when the low six phase bits are zero.
  always @(negedge clk) begin
    pop_phase <= pop_phase + 1;
    if (pop_phase[5:0] == 6'd0) begin
      pop_mode <= pop_mode_t'($urandom_range(0, 3));
    end
    case (pop_mode)
      POP_ALWAYS: pop <= 1'b1;
      POP_HALF:   pop <= 1'($urandom_range(0, 1));
      POP_SPARSE: pop <= (pop_phase[2:0] == 3'd0);
      default:    pop <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Compare each popped result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_payouts.size() == 0) begin
        $error("result transaction with no expectation waiting, status %0d", status);
        fail_count++;
      end else begin
        oldest_payout = expected_payouts.pop_front();
        check_field("status", GIVE_BITS'(oldest_payout.status), GIVE_BITS'(status));
        check_field("give_seventeen", oldest_payout.give[0], give_seventeen);
        check_field("give_eleven", oldest_payout.give[1], give_eleven);
        check_field("give_seven", oldest_payout.give[2], give_seven);
        check_field("give_five", oldest_payout.give[3], give_five);
        check_field("give_three", oldest_payout.give[4], give_three);
        check_field("give_two", oldest_payout.give[5], give_two);
        check_field("give_one", oldest_payout.give[6], give_one);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    int sat_index;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows, then a full pause of the sender.
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].cnt,
                directed_rows[i].pd, directed_rows[i].pr, directed_rows[i].has_status,
                directed_rows[i].want_status);
    end
    wait_for_results();

    send_random_mix(650);
    wait_for_results();

    // Drive one coin kind into saturation, then ask for large amounts.
    sat_index = $urandom_range(0, COIN_KINDS - 1);
    repeat (262) begin
      send_item(OP_REFILL, COIN_IDX_BITS'(sat_index), 8'd255,
                AMOUNT_BITS'($urandom_range(0, 255)),
                AMOUNT_BITS'($urandom_range(0, 255)), 1'b0, STATUS_OK);
    end
    repeat (40) begin
      send_item(OP_CHANGE, COIN_IDX_BITS'($urandom_range(0, 7)),
                COUNT_BITS'($urandom_range(0, 255)),
                AMOUNT_BITS'($urandom_range(200, 255)),
                AMOUNT_BITS'($urandom_range(0, 40)), 1'b0, STATUS_OK);
    end

    send_random_mix(280);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_payouts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
